// ----- hw/rtl/tea_pkg.sv -----
// Shared types, constants and the round mixing function of the TEA cipher.
package tea_pkg;

  localparam logic [31:0] TEA_DELTA       = 32'h9E37_79B9;
  localparam logic [31:0] TEA_DECRYPT_SUM = 32'hC6EF_3720;
  localparam int          TEA_ROUNDS      = 32;
  localparam int          TEA_STAGES      = 2 * TEA_ROUNDS;
  localparam int          KEY_WORDS       = 4;
  localparam int          CFG_IDX_W       = 3;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] KEY_IDX_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] KEY_IDX_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] KEY_IDX_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] KEY_IDX_3 = 3'd3;

  typedef struct packed {
    logic        command;
    logic [31:0] first_word;
    logic [31:0] second_word;
    logic        last_block;
  } tea_in_t;

  typedef struct packed {
    logic [31:0] result_first_word;
    logic [31:0] result_second_word;
    logic        result_last_block;
  } tea_out_t;

  typedef struct packed {
    logic        command;
    logic [31:0] y;
    logic [31:0] z;
    logic        last;
  } tea_stage_t;

  typedef struct packed {
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] k3;
  } tea_key_t;

  function automatic logic [31:0] tea_mix(input logic [31:0] v, input logic [31:0] sum,
                                          input logic [31:0] ka, input logic [31:0] kb);
    tea_mix = ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
  endfunction

endpackage

// ----- hw/rtl/tea_key_regs.sv -----
// Key word registers written through the configuration port.
module tea_key_regs import tea_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [31:0]          wr_data,
  output tea_key_t             key
);

  tea_key_t key_r;
  tea_key_t key_nxt;

  always_comb begin
    key_nxt = key_r;
    if (wr_en) begin
      case (wr_index)
        KEY_IDX_0: key_nxt.k0 = wr_data;
        KEY_IDX_1: key_nxt.k1 = wr_data;
        KEY_IDX_2: key_nxt.k2 = wr_data;
        KEY_IDX_3: key_nxt.k3 = wr_data;
        default:   key_nxt = key_r; // drop writes beyond the key words
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  assign key = key_r;

endmodule

// ----- hw/rtl/tea_round.sv -----
// One half-round pipeline stage, serving both encryption and decryption.
module tea_round import tea_pkg::*; #(
  parameter int STAGE_IDX = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_valid,
  input  tea_stage_t in_data,
  input  tea_key_t   key,
  output logic       valid_r,
  output tea_stage_t data_r
);

  localparam int          ROUND   = STAGE_IDX / 2;
  localparam bit          ODD     = (STAGE_IDX % 2) == 1;
  localparam logic [31:0] SUM_ENC = 32'(ROUND + 1) * TEA_DELTA;
  localparam logic [31:0] SUM_DEC = TEA_DECRYPT_SUM - 32'(ROUND) * TEA_DELTA;

  logic        dec;
  logic        use_k01;
  logic [31:0] src;
  logic [31:0] sum;
  logic [31:0] ka;
  logic [31:0] kb;
  logic [31:0] m;
  tea_stage_t  data_nxt;

  always_comb begin
    dec     = in_data.command == CMD_DECRYPT;
    // decryption runs the two halves in swapped order
    use_k01 = ODD ? dec : !dec;
    src     = use_k01 ? in_data.z : in_data.y;
    ka      = use_k01 ? key.k0 : key.k2;
    kb      = use_k01 ? key.k1 : key.k3;
    sum     = dec ? SUM_DEC : SUM_ENC;
    m       = tea_mix(src, sum, ka, kb);
    data_nxt = in_data;
    if (use_k01) begin
      data_nxt.y = dec ? in_data.y - m : in_data.y + m;
    end else begin
      data_nxt.z = dec ? in_data.z - m : in_data.z + m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- hw/rtl/tea_block_cipher.sv -----
// TEA block cipher top level: key registers and a 64-stage half-round pipeline.
// Requests move through the stages in order to out_valid; one half-round stage per
// register sets the depth. Throughput: one block per cycle unless stalled.
// A stalled result freezes every stage; the input takes a request in the same cycle
// the output result is taken. Synchronous reset clears all stage valid bits and the
// four key words to zero; payload registers are not reset.
module tea_block_cipher import tea_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tea_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tea_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  tea_key_t                key;
  logic                    en;
  logic [TEA_STAGES-1:0]   stage_valid;
  tea_stage_t              stage_data [TEA_STAGES];
  tea_stage_t              head;

  assign cfg_ready = 1'b1;

  tea_key_regs u_keys (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .key      (key)
  );

  // hold the whole pipeline while the finished result is stalled
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign head.command = in_data.command;
  assign head.y       = in_data.first_word;
  assign head.z       = in_data.second_word;
  assign head.last    = in_data.last_block;

  for (genvar k = 0; k < TEA_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      tea_round #(.STAGE_IDX(k)) u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .in_data  (head),
        .key      (key),
        .valid_r  (stage_valid[k]),
        .data_r   (stage_data[k])
      );
    end else begin : g_next
      tea_round #(.STAGE_IDX(k)) u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (stage_valid[k-1]),
        .in_data  (stage_data[k-1]),
        .key      (key),
        .valid_r  (stage_valid[k]),
        .data_r   (stage_data[k])
      );
    end
  end

  assign out_valid                   = stage_valid[TEA_STAGES-1];
  assign out_data.result_first_word  = stage_data[TEA_STAGES-1].y;
  assign out_data.result_second_word = stage_data[TEA_STAGES-1].z;
  assign out_data.result_last_block  = stage_data[TEA_STAGES-1].last;

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> stage_valid[0])
    else $error("accepted request did not enter the first stage");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(stage_valid))
    else $error("pipeline moved while the result was stalled");

  a_bad_index_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && cfg_index != KEY_IDX_0 && cfg_index != KEY_IDX_1 &&
    cfg_index != KEY_IDX_2 && cfg_index != KEY_IDX_3 |=> $stable(key))
    else $error("write beyond the key words changed the key");

endmodule

// ----- sim/tb_tea_block_cipher.sv -----
// Testbench for the TEA block cipher: directed and random blocks checked against a cipher model.
`timescale 1ns / 1ps

module tb_tea_block_cipher;
  import tea_pkg::*;

  localparam int CYCLE_LIMIT   = 400_000;
  localparam int PIPE_LATENCY  = TEA_STAGES;
  localparam int MAX_GAP       = 6;
  localparam int HOLD_CYCLES   = 200;
  localparam int PHASE_BLOCKS  = 110;
  localparam int RANDOM_PHASES = 4;
  localparam int BURST_BLOCKS  = 100;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  tea_in_t              in_data;
  logic                 out_valid;
  logic                 out_stall;
  tea_out_t             out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;

  tea_key_t    key_shadow;
  tea_out_t    pending_blocks [$];
  int          errors      = 0;
  int          cycle_count = 0;
  int          rx_hold_len = 0;
  bit          tx_idle_on  = 1'b0;
  bit          rx_idle_on  = 1'b0;

  always #1 clk = ~clk;

  tea_block_cipher DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  function automatic logic [31:0] half_round(input logic [31:0] v, input logic [31:0] sum,
                                             input logic [31:0] ka, input logic [31:0] kb);
    return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
  endfunction

  function automatic tea_out_t cipher_block(input tea_in_t blk);
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] sum;
    tea_out_t    res;
    y = blk.first_word;
    z = blk.second_word;
    if (blk.command == CMD_ENCRYPT) begin
      sum = '0;
      for (int i = 0; i < TEA_ROUNDS; i++) begin
        sum += TEA_DELTA;
        y += half_round(z, sum, key_shadow.k0, key_shadow.k1);
        z += half_round(y, sum, key_shadow.k2, key_shadow.k3);
      end
    end else begin
      // undo the half-rounds in reverse order
      sum = TEA_DECRYPT_SUM;
      for (int i = 0; i < TEA_ROUNDS; i++) begin
        z -= half_round(y, sum, key_shadow.k2, key_shadow.k3);
        y -= half_round(z, sum, key_shadow.k0, key_shadow.k1);
        sum -= TEA_DELTA;
      end
    end
    res.result_first_word  = y;
    res.result_second_word = z;
    res.result_last_block  = blk.last_block;
    return res;
  endfunction

  function automatic tea_in_t make_block(input logic cmd, input logic [31:0] y,
                                         input logic [31:0] z, input logic last);
    tea_in_t blk;
    blk.command     = cmd;
    blk.first_word  = y;
    blk.second_word = z;
    blk.last_block  = last;
    return blk;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic tea_in_t random_block();
    return make_block($urandom_range(0, 1) ? CMD_DECRYPT : CMD_ENCRYPT,
                      rand_word(), rand_word(), 1'($urandom_range(0, 1)));
  endfunction

  task automatic send_block(input tea_in_t blk);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= blk;
    do @(posedge clk); while (in_stall);
    pending_blocks.push_back(cipher_block(blk));
  endtask

  task automatic drain_blocks();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
  endtask

  task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      KEY_IDX_0: key_shadow.k0 = value;
      KEY_IDX_1: key_shadow.k1 = value;
      KEY_IDX_2: key_shadow.k2 = value;
      KEY_IDX_3: key_shadow.k3 = value;
      default:   ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                          input logic [31:0] k2, input logic [31:0] k3);
    write_key(KEY_IDX_0, k0);
    write_key(KEY_IDX_1, k1);
    write_key(KEY_IDX_2, k2);
    write_key(KEY_IDX_3, k3);
  endtask

  // Key never written: the reset key is all zero.
  task automatic test_reset_key();
    send_block(make_block(CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 1'b0));
    send_block(make_block(CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000, 1'b1));
    send_block(make_block(CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    send_block(make_block(CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    send_block(make_block(CMD_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0));
    send_block(make_block(CMD_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1));
    drain_blocks();
  endtask

  task automatic test_key_extremes();
    tea_out_t sealed;
    load_key('1, '1, '1, '1);
    send_block(make_block(CMD_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0));
    send_block(make_block(CMD_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1));
    send_block(make_block(CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    send_block(make_block(CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000, 1'b0));
    drain_blocks();
    load_key(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
    // decrypt the ciphertext of a block: must give the plaintext back
    sealed = cipher_block(make_block(CMD_ENCRYPT, 32'hDEAD_BEEF, 32'h0BAD_F00D, 1'b1));
    send_block(make_block(CMD_ENCRYPT, 32'hDEAD_BEEF, 32'h0BAD_F00D, 1'b1));
    send_block(make_block(CMD_DECRYPT, sealed.result_first_word,
                          sealed.result_second_word, 1'b0));
    send_block(make_block(CMD_ENCRYPT, 32'h8000_0000, 32'h0000_0001, 1'b0));
    send_block(make_block(CMD_DECRYPT, 32'h0000_0001, 32'h8000_0000, 1'b1));
    drain_blocks();
    // Register index out of range: the write must leave the key alone.
    for (int i = KEY_WORDS; i < (1 << CFG_IDX_W); i++)
      write_key(CFG_IDX_W'(i), '1);
    send_block(make_block(CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 1'b0));
    send_block(make_block(CMD_DECRYPT, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1));
    send_block(make_block(CMD_ENCRYPT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1));
    drain_blocks();
  endtask

  task automatic test_random_blocks();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_key(rand_word(), rand_word(), rand_word(), rand_word());
      for (int n = 0; n < PHASE_BLOCKS; n++) begin
        // switch idling on and off in stretches
        if (n % 20 == 0) begin
          tx_idle_on = $urandom_range(0, 3) != 0;
          rx_idle_on = $urandom_range(0, 3) != 0;
        end
        send_block(random_block());
      end
      drain_blocks();
    end
  endtask

  task automatic test_backpressure();
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b0;
    rx_hold_len = HOLD_CYCLES;
    repeat (BURST_BLOCKS) send_block(random_block());
    drain_blocks();
  endtask

  // Result side: draw a stall per request, plus a long hold-off on demand.
  initial begin
    int wait_len;
    out_stall = 1'b0;
    forever begin
      if (rx_hold_len > 0) begin
        repeat (rx_hold_len) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
        rx_hold_len = 0;
      end
      wait_len = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      repeat (wait_len) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall) && rx_hold_len == 0);
    end
  end

  always @(posedge clk) begin : check_result
    tea_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_blocks.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending: %h", $time, out_data);
      end else begin
        want = pending_blocks.pop_front();
        if (out_data.result_first_word !== want.result_first_word) begin
          errors++;
          $display("%0t: first word expected %h got %h", $time,
                   want.result_first_word, out_data.result_first_word);
        end
        if (out_data.result_second_word !== want.result_second_word) begin
          errors++;
          $display("%0t: second word expected %h got %h", $time,
                   want.result_second_word, out_data.result_second_word);
        end
        if (out_data.result_last_block !== want.result_last_block) begin
          errors++;
          $display("%0t: last flag expected %b got %b", $time,
                   want.result_last_block, out_data.result_last_block);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    key_shadow = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_key();
    test_key_extremes();
    test_random_blocks();
    test_backpressure();

    repeat (PIPE_LATENCY + 16) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
